[rtl/lgs_pkg.sv]
// Shared types and constants for the life generation stencil.
// No dependencies; imported by every other file of the block but lgs_ram.
package lgs_pkg;

   // Configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 11;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_GRID_WIDTH  = 1'b0,
      REG_GRID_HEIGHT = 1'b1
   } csr_index_type;

   // Request operation codes
   typedef enum logic {
      OP_CELL  = 1'b0,
      OP_DRAIN = 1'b1
   } op_type;

   // Birth and survival neighbor counts of the B3/S23 rule
   localparam logic [3:0] BIRTH_COUNT   = 4'd3;
   localparam logic [3:0] SURVIVE_COUNT = 4'd2;

   localparam int RESET_GRID_DIM = 1000;

   typedef struct packed {
      op_type op;
      logic   cell_alive;
   } req_payload_type;

   typedef struct packed {
      logic next_alive;
      logic last;
   } rsp_payload_type;

endpackage

[rtl/lgs_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; the read data holds while the read enable is low.
module lgs_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2051
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic                     read_enable,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

[rtl/life_generation_stencil.sv]
// One generation of the B3/S23 life rule over a raster cell stream.
// Depends on lgs_pkg and lgs_ram (two copies of the cell history memory).
//
// Usage: the current generation enters on the request channel (req_valid,
// req_stall, req_payload), one cell per request in raster order, row 0 first
// and column 0 first in each row. After the W*H cells of a frame, W+1 drain
// requests flush the last results; further drain requests are accepted and
// give nothing. Each request from stream position W+1 on yields one response
// on rsp_valid/rsp_stall/rsp_payload carrying the next state of the cell W+1
// positions back; last marks the final cell of the generation.
// Path: an accepted request is registered in stage 1 along with its memory read
// data, then its response in the output register, where it can be taken.
// Throughput: one request per cycle while req_stall is low; the two memory read
// ports fetch the upper and middle row cells of the window column for each live
// request. If the receiver stalls, the output register holds its response and
// stage 1 holds one more; req_stall is high only while stage 1 waits behind it.
// Reset (synchronous, active high) clears the stream position, the window and
// both pipeline stages and sets both grid dimensions to 1000. Dimensions are
// written on the csr_ port between frames; zero reads as one and values above
// the maximum as the maximum. Cells outside the grid count as dead.
module life_generation_stencil #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  lgs_pkg::req_payload_type      req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output lgs_pkg::rsp_payload_type      rsp_payload,
   input  logic                          csr_we,
   input  logic [lgs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lgs_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import lgs_pkg::*;

   localparam int DimW      = $clog2(MAX_WIDTH + 1);
   localparam int HgtW      = $clog2(MAX_HEIGHT + 1);
   localparam int ColW      = $clog2(MAX_WIDTH);
   localparam int RowW      = $clog2(MAX_HEIGHT);
   localparam int PosW      = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 1);
   localparam int HistDepth = 2 * MAX_WIDTH + 3;
   localparam int SlotW     = $clog2(HistDepth);
   localparam int ResetW    = (RESET_GRID_DIM > MAX_WIDTH) ? MAX_WIDTH : RESET_GRID_DIM;
   localparam int ResetH    = (RESET_GRID_DIM > MAX_HEIGHT) ? MAX_HEIGHT : RESET_GRID_DIM;
   localparam int CmpW      = 14;
   localparam logic [SlotW:0] HistWide = (SlotW+1)'(HistDepth);

   // ---------------------------------------------------------------------
   // Configuration registers, stored already limited to their legal range.
   // ---------------------------------------------------------------------
   logic [DimW-1:0]   width_ff, width_in;
   logic [HgtW-1:0]   height_ff, height_in;
   logic [CmpW-1:0]   wdata_wide;

   assign wdata_wide = CmpW'(csr_wdata);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            REG_GRID_WIDTH: begin
               if (wdata_wide == '0) begin
                  width_in = DimW'(1);
               end else if (wdata_wide > CmpW'(MAX_WIDTH)) begin
                  width_in = DimW'(MAX_WIDTH);
               end else begin
                  width_in = DimW'(wdata_wide);
               end
            end
            REG_GRID_HEIGHT: begin
               if (wdata_wide == '0) begin
                  height_in = HgtW'(1);
               end else if (wdata_wide > CmpW'(MAX_HEIGHT)) begin
                  height_in = HgtW'(MAX_HEIGHT);
               end else begin
                  height_in = HgtW'(wdata_wide);
               end
            end
            default: begin
               width_in  = width_ff;
               height_in = height_ff;
            end
         endcase
      end
   end

   // Frame size and the position at which the frame ends.
   logic [PosW-1:0] total_cells;
   logic [PosW-1:0] end_pos;

   assign total_cells = PosW'(width_ff) * PosW'(height_ff);
   assign end_pos     = total_cells + PosW'(width_ff);

   // ---------------------------------------------------------------------
   // Stage 0: position bookkeeping, history write and row reads.
   // ---------------------------------------------------------------------
   logic [PosW-1:0]  pos_ff, pos_in;
   logic [SlotW-1:0] slot_ff, slot_in;
   logic [ColW-1:0]  col_ff, col_in;
   logic [RowW-1:0]  row_ff, row_in;

   logic             req_accept;
   logic             step_surplus;
   logic             step_overrun;
   logic             step_live;
   logic             step_emit;
   logic             step_write;
   logic             col_is_last;
   logic             row_is_last;
   logic             cell_bit;
   logic [SlotW-1:0] slot_next;
   logic [SlotW:0]   upper_sum;
   logic [SlotW:0]   middle_sum;
   logic [SlotW-1:0] upper_slot;
   logic [SlotW-1:0] middle_slot;

   assign req_accept   = req_valid && !req_stall;
   assign step_surplus = (req_payload.op == OP_DRAIN) && (pos_ff == '0);
   assign step_overrun = pos_ff > end_pos;
   assign step_live    = req_accept && !step_surplus && !step_overrun;
   assign step_emit    = pos_ff >= (PosW'(width_ff) + PosW'(1));
   assign step_write   = step_live && (pos_ff < total_cells);
   assign cell_bit     = (req_payload.op == OP_CELL) && req_payload.cell_alive;

   assign col_is_last  = DimW'(col_ff) == (width_ff - DimW'(1));
   assign row_is_last  = HgtW'(row_ff) == (height_ff - HgtW'(1));

   assign slot_next = (slot_ff == SlotW'(HistDepth - 1)) ? '0 : slot_ff + SlotW'(1);

   // History slots of positions p-2W and p-W, modulo the history depth.
   assign upper_sum   = {1'b0, slot_ff} + HistWide - ((SlotW+1)'(width_ff) << 1);
   assign middle_sum  = {1'b0, slot_ff} + HistWide - (SlotW+1)'(width_ff);
   assign upper_slot  = (upper_sum >= HistWide) ? SlotW'(upper_sum - HistWide)
                                                : SlotW'(upper_sum);
   assign middle_slot = (middle_sum >= HistWide) ? SlotW'(middle_sum - HistWide)
                                                 : SlotW'(middle_sum);

   always_comb begin
      pos_in  = pos_ff;
      slot_in = slot_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      priority if (req_accept && !step_surplus && step_overrun) begin
         pos_in  = '0;
         slot_in = '0;
         col_in  = '0;
         row_in  = '0;
      end else if (step_live) begin
         if (pos_ff == end_pos) begin
            pos_in  = '0;
            slot_in = '0;
            col_in  = '0;
            row_in  = '0;
         end else begin
            pos_in  = pos_ff + PosW'(1);
            slot_in = slot_next;
            if (step_emit) begin
               if (col_is_last) begin
                  col_in = '0;
                  row_in = row_ff + RowW'(1);
               end else begin
                  col_in = col_ff + ColW'(1);
               end
            end
         end
      end
   end

   logic upper_bit;
   logic middle_bit;

   lgs_ram #(
      .WIDTH (1),
      .DEPTH (HistDepth)
   ) u_upper_ram (
      .clock        (clock),
      .write_enable (step_write),
      .write_addr   (slot_ff),
      .write_data   (cell_bit),
      .read_enable  (step_live),
      .read_addr    (upper_slot),
      .read_data    (upper_bit)
   );

   lgs_ram #(
      .WIDTH (1),
      .DEPTH (HistDepth)
   ) u_middle_ram (
      .clock        (clock),
      .write_enable (step_write),
      .write_addr   (slot_ff),
      .write_data   (cell_bit),
      .read_enable  (step_live),
      .read_addr    (middle_slot),
      .read_data    (middle_bit)
   );

   // ---------------------------------------------------------------------
   // Stage 1: the memory data has arrived; the window column is complete.
   // Columns hold {bottom, middle, upper} of one raster column.
   // ---------------------------------------------------------------------
   logic       rsp_valid_ff, rsp_valid_in;
   logic       s1_valid_ff, s1_valid_in;
   logic       s1_emit_ff;
   logic       s1_bottom_ff;
   logic       s1_left_ok_ff;
   logic       s1_right_ok_ff;
   logic       s1_up_ok_ff;
   logic       s1_down_ok_ff;
   logic       s1_last_ff;
   logic [2:0] left_col_ff, left_col_in;
   logic [2:0] center_col_ff, center_col_in;

   logic       s1_go;
   logic [2:0] right_col;
   logic [2:0] row_mask;
   logic [2:0] left_m;
   logic [2:0] center_m;
   logic [2:0] right_m;
   logic [7:0] neighbors;
   logic [3:0] live_count;
   logic       next_alive;

   // Stage 1 retires unless it holds a response and the output is blocked.
   assign s1_go     = s1_valid_ff && (!s1_emit_ff || !rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_go;

   assign right_col = {s1_bottom_ff, middle_bit, upper_bit};
   assign row_mask  = {s1_down_ok_ff, 1'b1, s1_up_ok_ff};
   assign left_m    = left_col_ff & row_mask & {3{s1_left_ok_ff}};
   assign center_m  = center_col_ff & row_mask;
   assign right_m   = right_col & row_mask & {3{s1_right_ok_ff}};
   assign neighbors = {left_m, right_m, center_m[2], center_m[0]};
   assign live_count = 4'($countones(neighbors));
   assign next_alive = (live_count == BIRTH_COUNT)
                    || (center_m[1] && (live_count == SURVIVE_COUNT));

   assign s1_valid_in   = step_live || (s1_valid_ff && !s1_go);
   assign left_col_in   = s1_go ? center_col_ff : left_col_ff;
   assign center_col_in = s1_go ? right_col : center_col_ff;

   // ---------------------------------------------------------------------
   // Output register.
   // ---------------------------------------------------------------------
   rsp_payload_type rsp_data_ff, rsp_data_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (s1_go && s1_emit_ff) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.next_alive = next_alive;
         rsp_data_in.last       = s1_last_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // ---------------------------------------------------------------------
   // Registers.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= DimW'(ResetW);
         height_ff     <= HgtW'(ResetH);
         pos_ff        <= '0;
         slot_ff       <= '0;
         col_ff        <= '0;
         row_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         left_col_ff   <= '0;
         center_col_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         width_ff      <= width_in;
         height_ff     <= height_in;
         pos_ff        <= pos_in;
         slot_ff       <= slot_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         s1_valid_ff   <= s1_valid_in;
         left_col_ff   <= left_col_in;
         center_col_ff <= center_col_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Stage 1 payload, loaded with each request that takes a position.
   always_ff @(posedge clock) begin
      if (step_live) begin
         s1_emit_ff     <= step_emit;
         s1_bottom_ff   <= cell_bit;
         s1_left_ok_ff  <= col_ff != '0;
         s1_right_ok_ff <= !col_is_last;
         s1_up_ok_ff    <= row_ff != '0;
         s1_down_ok_ff  <= !row_is_last;
         s1_last_ff     <= col_is_last && row_is_last;
      end
      rsp_data_ff <= rsp_data_in;
   end

endmodule

[rtl/lgs_checker.sv]
// Port-level checks for life_generation_stencil, attached by bind.
// Depends on lgs_pkg for the payload types.
module lgs_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input lgs_pkg::rsp_payload_type rsp_payload
);

   // A blocked response stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   // A fresh response follows an accepted request, via stage 1 and the output register.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("response without a matching request");

   // With the response register empty, requests are never held off.
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled while the output is empty");

endmodule

bind life_generation_stencil lgs_checker u_lgs_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

[test/testbench.sv]
// Self-checking testbench for life_generation_stencil: one life generation per frame.
// Depends on lgs_pkg and the block's RTL. It carries its own next-state predictor,
// a stimulus table, random frames and random idling on both channels.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import lgs_pkg::*;

   localparam int GRID_MAX_W = 1024;
   localparam int GRID_MAX_H = 1024;
   // The predictor keeps the last two rows plus the three cells of the window.
   localparam int HIST_DEPTH = 2 * GRID_MAX_W + 3;
   // Settling time after the last response, so that requests with no response are done too.
   localparam int QUIET_CYCLES = 8;
   localparam int DRAIN_GUARD = 4000;
   localparam int NUM_EXTREME = 5;
   localparam int TARGET_REQUESTS = 450;

   // One row of the directed stimulus. A row either writes a register or sends
   // one request. Typed rows carry their response as read off the rules.
   typedef struct packed {
      bit              is_write;
      csr_index_type   reg_sel;
      logic [10:0]     reg_value;
      op_type          op;
      logic            alive;
      bit              typed;
      bit              rsp_present;
      rsp_payload_type typed_rsp;
   } plan_row_type;

   // Columns: is_write, reg_sel, reg_value, op, alive, typed, rsp_present, typed_rsp.
   localparam plan_row_type DIRECTED_PLAN [28] = '{
      // Drains with no frame in progress are ignored, alive bit or not.
      '{1'b0, REG_GRID_WIDTH,  11'd0, OP_DRAIN, 1'b0, 1'b1, 1'b0, '{1'b0, 1'b0}},
      '{1'b0, REG_GRID_WIDTH,  11'd0, OP_DRAIN, 1'b1, 1'b1, 1'b0, '{1'b0, 1'b0}},
      // A single live cell on a 1x1 grid has no neighbors and dies.
      '{1'b1, REG_GRID_WIDTH,  11'd1, OP_CELL,  1'b0, 1'b0, 1'b0, '{1'b0, 1'b0}},
      '{1'b1, REG_GRID_HEIGHT, 11'd1, OP_CELL,  1'b0, 1'b0, 1'b0, '{1'b0, 1'b0}},
      '{1'b0, REG_GRID_WIDTH,  11'd0, OP_CELL,  1'b1, 1'b1, 1'b0, '{1'b0, 1'b0}},
      '{1'b0, REG_GRID_WIDTH,  11'd0, OP_DRAIN, 1'b0, 1'b1, 1'b0, '{1'b0, 1'b0}},
      '{1'b0, REG_GRID_WIDTH,  11'd0, OP_DRAIN, 1'b0, 1'b1, 1'b1, '{1'b0, 1'b1}},
      '{1'b0, REG_GRID_WIDTH,  11'd0, OP_DRAIN, 1'b1, 1'b1, 1'b0, '{1'b0, 1'b0}},
      // Zero dimensions read as one; a late cell stands in for a drain.
      '{1'b1, REG_GRID_WIDTH,  11'd0, OP_CELL,  1'b0, 1'b0, 1'b0, '{1'b0, 1'b0}},
      '{1'b1, REG_GRID_HEIGHT, 11'd0, OP_CELL,  1'b0, 1'b0, 1'b0, '{1'b0, 1'b0}},
      '{1'b0, REG_GRID_WIDTH,  11'd0, OP_CELL,  1'b0, 1'b1, 1'b0, '{1'b0, 1'b0}},
      '{1'b0, REG_GRID_WIDTH,  11'd0, OP_CELL,  1'b1, 1'b1, 1'b0, '{1'b0, 1'b0}},
      '{1'b0, REG_GRID_WIDTH,  11'd0, OP_DRAIN, 1'b0, 1'b1, 1'b1, '{1'b0, 1'b1}},
      // A full 3x3 block with a drain in its center, then a mixed flush.
      '{1'b1, REG_GRID_WIDTH,  11'd3, OP_CELL,  1'b0, 1'b0, 1'b0, '{1'b0, 1'b0}},
      '{1'b1, REG_GRID_HEIGHT, 11'd3, OP_CELL,  1'b0, 1'b0, 1'b0, '{1'b0, 1'b0}},
      '{1'b0, REG_GRID_WIDTH,  11'd0, OP_CELL,  1'b1, 1'b0, 1'b0, '{1'b0, 1'b0}},
      '{1'b0, REG_GRID_WIDTH,  11'd0, OP_CELL,  1'b1, 1'b0, 1'b0, '{1'b0, 1'b0}},
      '{1'b0, REG_GRID_WIDTH,  11'd0, OP_CELL,  1'b1, 1'b0, 1'b0, '{1'b0, 1'b0}},
      '{1'b0, REG_GRID_WIDTH,  11'd0, OP_CELL,  1'b1, 1'b0, 1'b0, '{1'b0, 1'b0}},
      '{1'b0, REG_GRID_WIDTH,  11'd0, OP_DRAIN, 1'b1, 1'b0, 1'b0, '{1'b0, 1'b0}},
      '{1'b0, REG_GRID_WIDTH,  11'd0, OP_CELL,  1'b1, 1'b0, 1'b0, '{1'b0, 1'b0}},
      '{1'b0, REG_GRID_WIDTH,  11'd0, OP_CELL,  1'b1, 1'b0, 1'b0, '{1'b0, 1'b0}},
      '{1'b0, REG_GRID_WIDTH,  11'd0, OP_CELL,  1'b1, 1'b0, 1'b0, '{1'b0, 1'b0}},
      '{1'b0, REG_GRID_WIDTH,  11'd0, OP_CELL,  1'b1, 1'b0, 1'b0, '{1'b0, 1'b0}},
      '{1'b0, REG_GRID_WIDTH,  11'd0, OP_CELL,  1'b1, 1'b0, 1'b0, '{1'b0, 1'b0}},
      '{1'b0, REG_GRID_WIDTH,  11'd0, OP_DRAIN, 1'b0, 1'b0, 1'b0, '{1'b0, 1'b0}},
      '{1'b0, REG_GRID_WIDTH,  11'd0, OP_CELL,  1'b0, 1'b0, 1'b0, '{1'b0, 1'b0}},
      '{1'b0, REG_GRID_WIDTH,  11'd0, OP_DRAIN, 1'b1, 1'b0, 1'b0, '{1'b0, 1'b0}}
   };

   // Edge grid shapes, raw register values: a single column, a single row,
   // zero dimensions that read as one, and a wide, shallow frame.
   localparam logic [10:0] EXTREME_W [NUM_EXTREME] = '{11'd1, 11'd40, 11'd0, 11'd2, 11'd16};
   localparam logic [10:0] EXTREME_H [NUM_EXTREME] = '{11'd40, 11'd1, 11'd0, 11'd0, 11'd8};

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_payload_type        req_payload = '{op: OP_CELL, cell_alive: 1'b0};
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_payload_type        rsp_payload;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Predictor state: register shadows, cell history and the frame position.
   logic [10:0]     grid_width_shadow = 11'd1000;
   logic [10:0]     grid_height_shadow = 11'd1000;
   logic            past_cells [HIST_DEPTH];
   int unsigned     frame_position = 0;

   rsp_payload_type expected_next_cells [$];
   int unsigned     fault_count = 0;
   int unsigned     responses_checked = 0;
   int unsigned     requests_sent = 0;
   // While set, neither side idles: a long stretch of full-rate traffic.
   bit              steady_run = 1'b0;

   life_generation_stencil #(
      .MAX_WIDTH (GRID_MAX_W),
      .MAX_HEIGHT(GRID_MAX_H)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Register values are limited to 1..max before use.
   function automatic int unsigned grid_dim(input logic [10:0] raw, input int unsigned hi);
      if (raw == 11'd0) return 1;
      if (raw > hi) return hi;
      return raw;
   endfunction

   // Cells outside the grid count as dead; there is no wrap-around.
   function automatic logic history_cell(input int r, input int c, input int w, input int h);
      if (r < 0 || c < 0 || r >= h || c >= w) return 1'b0;
      return past_cells[(r * w + c) % HIST_DEPTH];
   endfunction

   // Advances the predictor by one accepted request. Returns 1 when the request
   // yields a response, the next state of the cell W+1 positions back.
   function automatic bit predict_next_state(input op_type op, input logic alive,
                                             output rsp_payload_type res);
      int unsigned w, h, total, p, k;
      int          r, c, dr, dc, count;
      logic        self_alive;
      bit          produced;
      w = grid_dim(grid_width_shadow, GRID_MAX_W);
      h = grid_dim(grid_height_shadow, GRID_MAX_H);
      total = w * h;
      p = frame_position;
      res = '{next_alive: 1'b0, last: 1'b0};
      produced = 1'b0;
      // A drain with no frame in progress takes no position.
      if (op == OP_DRAIN && p == 0) return 1'b0;
      // Only reachable when the grid shrinks mid-frame.
      if (p > total + w) begin
         frame_position = 0;
         return 1'b0;
      end
      // Early drains store a dead cell; late cells are not stored at all.
      if (p < total) past_cells[p % HIST_DEPTH] = (op == OP_CELL) ? alive : 1'b0;
      if (p >= w + 1) begin
         k = p - w - 1;
         r = k / w;
         c = k % w;
         count = 0;
         for (dr = -1; dr <= 1; dr++) begin
            for (dc = -1; dc <= 1; dc++) begin
               if ((dr != 0 || dc != 0) && history_cell(r + dr, c + dc, w, h)) count++;
            end
         end
         self_alive = history_cell(r, c, w, h);
         res.next_alive = (count == BIRTH_COUNT) || (self_alive && count == SURVIVE_COUNT);
         res.last = (k == total - 1);
         produced = 1'b1;
      end
      frame_position = (p == total + w) ? 0 : p + 1;
      return produced;
   endfunction

   // Offers one request, idling at random first, and returns at the falling edge
   // after it was accepted with the predicted response, if any.
   task automatic send_request(input op_type op, input logic alive,
                               output bit produced, output rsp_payload_type res);
      while (!steady_run && $urandom_range(0, 99) < 25) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{op: op, cell_alive: alive};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      produced = predict_next_state(op, alive, res);
      requests_sent++;
      @(negedge clock);
   endtask

   // Holds the sender off until every expected response has arrived, then lets
   // the pipeline settle so that requests with no response are done too.
   task automatic wait_generation_drained();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (expected_next_cells.size() != 0 && guard < DRAIN_GUARD) begin
         @(negedge clock);
         guard++;
      end
      if (expected_next_cells.size() != 0) begin
         $error("%0d responses never arrived", expected_next_cells.size());
         fault_count++;
         expected_next_cells.delete();
      end
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   // One register write; returns only after the write enable has been dropped, so that back-to-back
   // writes never assign the write enable twice in one time step.
   task automatic write_grid_reg(input csr_index_type sel, input logic [10:0] value);
      csr_we <= 1'b1;
      csr_index <= sel;
      csr_wdata <= value;
      if (sel == REG_GRID_WIDTH) grid_width_shadow = value;
      else grid_height_shadow = value;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // The receiver stalls about a quarter of the time, except in the steady stretch.
   always @(negedge clock) begin
      rsp_stall <= !reset && !steady_run && ($urandom_range(0, 99) < 25);
   end

   // Every accepted response is compared with the oldest prediction.
   always @(posedge clock) begin : check_responses
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_next_cells.size() == 0) begin
            $error("response with nothing expected: next_alive %0b, last %0b",
                   rsp_payload.next_alive, rsp_payload.last);
            fault_count++;
         end else begin
            want = expected_next_cells.pop_front();
            responses_checked++;
            if (rsp_payload.next_alive !== want.next_alive) begin
               $error("next_alive mismatch: expected %0b, got %0b",
                      want.next_alive, rsp_payload.next_alive);
               fault_count++;
            end
            if (rsp_payload.last !== want.last) begin
               $error("last mismatch: expected %0b, got %0b", want.last, rsp_payload.last);
               fault_count++;
            end
         end
      end
   end

   initial begin : stimulus
      bit              produced;
      rsp_payload_type res;
      plan_row_type    row;
      int unsigned     frame_no, extreme_idx;
      int unsigned     w_eff, h_eff, cells, density, pause_at, i;
      logic [10:0]     w_raw, h_raw;
      bit              is_extreme;
      op_type          op;

      for (i = 0; i < HIST_DEPTH; i++) past_cells[i] = 1'b0;

      // Synchronous reset, released on a falling edge.
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part. Register writes only happen once the block is idle.
      foreach (DIRECTED_PLAN[n]) begin
         row = DIRECTED_PLAN[n];
         if (row.is_write) begin
            wait_generation_drained();
            write_grid_reg(row.reg_sel, row.reg_value);
         end else begin
            send_request(row.op, row.alive, produced, res);
            if (row.typed) begin
               if (row.rsp_present) expected_next_cells.push_back(row.typed_rsp);
            end else if (produced) begin
               expected_next_cells.push_back(res);
            end
         end
      end

      // Random part: whole frames with random content. Every second frame uses
      // one of the edge shapes until all are done.
      frame_no = 0;
      extreme_idx = 0;
      while (requests_sent < TARGET_REQUESTS || extreme_idx < NUM_EXTREME) begin
         is_extreme = (frame_no % 2 == 1) && (extreme_idx < NUM_EXTREME);
         if (is_extreme) begin
            w_raw = EXTREME_W[extreme_idx];
            h_raw = EXTREME_H[extreme_idx];
            extreme_idx++;
         end else begin
            w_raw = 11'($urandom_range(0, 12));
            h_raw = 11'($urandom_range(0, 10));
         end
         // A few frames in the middle of the run go at full rate on both sides.
         steady_run = (frame_no >= 6 && frame_no <= 8);

         wait_generation_drained();
         write_grid_reg(REG_GRID_WIDTH, w_raw);
         write_grid_reg(REG_GRID_HEIGHT, h_raw);
         w_eff = grid_dim(w_raw, GRID_MAX_W);
         h_eff = grid_dim(h_raw, GRID_MAX_H);
         cells = w_eff * h_eff;
         density = $urandom_range(0, 100);
         // About one frame in four pauses mid-frame until all responses are in;
         // the first frame always does.
         pause_at = (frame_no == 0) ? cells / 2 : $urandom_range(0, 4 * cells);

         for (i = 0; i < cells; i++) begin
            if (i == pause_at) wait_generation_drained();
            // Occasional early drains stand for dead cells.
            op = ($urandom_range(0, 99) < 5) ? OP_DRAIN : OP_CELL;
            send_request(op, $urandom_range(0, 99) < density, produced, res);
            if (produced) expected_next_cells.push_back(res);
         end
         // The flush mixes drains with late cells, which act as drains.
         for (i = 0; i <= w_eff; i++) begin
            op = $urandom_range(0, 1) ? OP_DRAIN : OP_CELL;
            send_request(op, 1'($urandom_range(0, 1)), produced, res);
            if (produced) expected_next_cells.push_back(res);
         end
         // Surplus drains after the frame must be ignored.
         repeat ($urandom_range(0, 2)) begin
            send_request(OP_DRAIN, 1'($urandom_range(0, 1)), produced, res);
            if (produced) expected_next_cells.push_back(res);
         end
         frame_no++;
      end
      steady_run = 1'b0;

      wait_generation_drained();
      $display("Run covered %0d random frames (%0d of edge shapes) and %0d requests,",
               frame_no, NUM_EXTREME, requests_sent);
      $display("with %0d responses checked against the predicted next generation.",
               responses_checked);
      if (fault_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("testbench: FAIL");
      $finish;
   end

endmodule
